/* sv/lif_neuron_update_core_defines.svh */
// Assertion macros shared by the neuron update core.
// Assertions are clocked by i_clk and are disabled while i_rst_n is low.
`ifndef LIF_NEURON_UPDATE_CORE_DEFINES_SVH
`define LIF_NEURON_UPDATE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIFNU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIFNU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/lifnu_pkg.sv */
// Types, register codes, constants and the saturating function for the neuron update core.
// No dependencies; used by every module of the block.
package lifnu_pkg;

    localparam int unsigned NEURON_W = 4;
    localparam int unsigned MEM_W    = 32;
    localparam int unsigned SPIKE_W  = 16;
    localparam int unsigned GAIN_W   = 16;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    localparam logic signed [MEM_W-1:0] THRESHOLD_RST   = 32'sd65536;
    localparam logic [GAIN_W-1:0]       GAIN_RST        = 16'h8000;
    localparam logic signed [MEM_W-1:0] RESET_VALUE_RST = 32'sd0;
    localparam logic                    HARD_MODE_RST   = 1'b1;
    localparam logic signed [MEM_W-1:0] RESET_MINUS_ONE = -32'sd65536;
    localparam logic signed [49:0]      ROUND_HALF      = 50'sd16384;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        REG_FIRE_THRESHOLD = 2'd0,
        REG_DECAY_GAIN     = 2'd1,
        REG_RESET_VALUE    = 2'd2,
        REG_HARD_MODE      = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_action                     action;
        logic [NEURON_W-1:0]         neuron;
        logic signed [SPIKE_W-1:0]   spike_value;
        logic signed [MEM_W-1:0]     membrane_load;
        logic                        last_step;
    } t_in_item;

    typedef struct packed {
        logic [NEURON_W-1:0]         result_neuron;
        logic                        spike_out;
        logic signed [MEM_W-1:0]     membrane_out;
        logic                        final_membrane;
    } t_out_item;

    typedef struct packed {
        logic signed [MEM_W-1:0]     fire_threshold;
        logic [GAIN_W-1:0]           decay_gain;
        logic signed [MEM_W-1:0]     reset_value;
        logic                        hard_mode;
    } t_cfg;

    function automatic logic signed [MEM_W-1:0] sat32(input logic signed [35:0] v);
        logic signed [MEM_W-1:0] res;
        if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
            res = v[31:0];
        end else if (v[35]) begin
            res = {1'b1, {(MEM_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(MEM_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

/* sv/lifnu_cfg_regs.sv */
// Configuration registers of the neuron update core behind an APB-style port.
// Depends on lifnu_pkg for the register codes, reset values and t_cfg.
module lifnu_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lifnu_pkg::APB_AW-1:0]  paddr,
    input  logic [lifnu_pkg::APB_DW-1:0]  pwdata,
    output logic [lifnu_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    output lifnu_pkg::t_cfg               o_cfg
);
    import lifnu_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_reg;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fire_threshold <= THRESHOLD_RST;
            r_cfg.decay_gain     <= GAIN_RST;
            r_cfg.reset_value    <= RESET_VALUE_RST;
            r_cfg.hard_mode      <= HARD_MODE_RST;
        end else if (w_wr) begin
            case (w_reg)
                REG_FIRE_THRESHOLD: r_cfg.fire_threshold <= pwdata;
                REG_DECAY_GAIN:     r_cfg.decay_gain     <= pwdata[GAIN_W-1:0];
                REG_RESET_VALUE:    r_cfg.reset_value    <= pwdata;
                REG_HARD_MODE:      r_cfg.hard_mode      <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_FIRE_THRESHOLD: prdata = r_cfg.fire_threshold;
            REG_DECAY_GAIN:     prdata = {{(APB_DW-GAIN_W){1'b0}}, r_cfg.decay_gain};
            REG_RESET_VALUE:    prdata = r_cfg.reset_value;
            REG_HARD_MODE:      prdata = {{(APB_DW-1){1'b0}}, r_cfg.hard_mode};
            default:            prdata = '0;
        endcase
    end

endmodule

/* sv/lifnu_update.sv */
// Single-pass membrane update: decay multiply, spike add, threshold compare and reset; loads pass through.
// Depends on lifnu_pkg for the item and configuration types and saturation.
module lifnu_update (
    input  lifnu_pkg::t_in_item              i_item,
    input  logic signed [lifnu_pkg::MEM_W-1:0] i_membrane,
    input  lifnu_pkg::t_cfg                  i_cfg,
    output logic                             o_fired,
    output logic signed [lifnu_pkg::MEM_W-1:0] o_membrane
);
    import lifnu_pkg::*;

    logic signed [48:0]       w_prod;
    logic signed [49:0]       w_round;
    logic signed [34:0]       w_dec;
    logic signed [35:0]       w_sum_wide;
    logic signed [MEM_W-1:0]  w_sum;
    logic                     w_fire;
    logic signed [MEM_W-1:0]  w_rst;
    logic signed [MEM_W:0]    w_diff;
    logic signed [MEM_W-1:0]  w_soft;

    assign w_prod     = i_membrane * $signed({1'b0, i_cfg.decay_gain});
    assign w_round    = {w_prod[48], w_prod} + ROUND_HALF;
    assign w_dec      = w_round[49:15];
    assign w_sum_wide = {w_dec[34], w_dec}
                      + {{4{i_item.spike_value[SPIKE_W-1]}}, i_item.spike_value, 16'b0};
    assign w_sum      = sat32(w_sum_wide);
    assign w_fire     = (w_sum >= i_cfg.fire_threshold);
    assign w_rst      = (i_cfg.reset_value == RESET_MINUS_ONE) ? '0 : i_cfg.reset_value;
    assign w_diff     = {w_sum[MEM_W-1], w_sum} - {w_rst[MEM_W-1], w_rst};
    assign w_soft     = sat32({{3{w_diff[MEM_W]}}, w_diff});

    always_comb begin
        if (i_item.action == ACT_LOAD) begin
            o_fired    = 1'b0;
            o_membrane = i_item.membrane_load;
        end else if (w_fire) begin
            o_fired    = 1'b1;
            o_membrane = i_cfg.hard_mode ? w_rst : w_soft;
        end else begin
            o_fired    = 1'b0;
            o_membrane = w_sum;
        end
    end

endmodule

/* sv/lif_neuron_update_core.sv */
// Top level of the leaky integrate-and-fire neuron update core.
// Depends on lifnu_pkg, lifnu_cfg_regs, lifnu_update and the defines header.
//
// Items enter on i_in_valid/o_in_stall and results leave on o_out_valid/i_out_stall.
// An item is taken at a clock edge with valid high and stall low.
// Every item yields exactly one result item, in order.
// A load item writes the addressed neuron's membrane and echoes it.
// A step item decays, integrates and thresholds the stored membrane and writes it back.
// An item is captured in an input register; the multiply, add and compare are combinational,
// and the result is written to the output register.
// Without receiver stalls one item per cycle is sustained; the next item reads the membrane already written.
// When the receiver stalls, the held result waits and one more item is still taken.
// Synchronous reset clears all membranes to zero and loads the register defaults.
// Write configuration through the APB-style port only while the core is idle; the core does not check it.
`include "lif_neuron_update_core_defines.svh"

module lif_neuron_update_core #(
    parameter int NEURONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lifnu_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lifnu_pkg::t_out_item          o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lifnu_pkg::APB_AW-1:0]  paddr,
    input  logic [lifnu_pkg::APB_DW-1:0]  pwdata,
    output logic [lifnu_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import lifnu_pkg::*;

    localparam int IDX_W = (NEURONS > 1) ? $clog2(NEURONS) : 1;

    t_cfg                    w_cfg;
    logic                    r_in_v;
    logic                    n_in_v;
    t_in_item                r_in;
    logic                    r_out_v;
    logic                    n_out_v;
    t_out_item               r_out;
    t_out_item               n_out;
    logic signed [MEM_W-1:0] r_mem [NEURONS];
    logic                    w_adv;
    logic                    w_accept;
    logic                    w_valid;
    logic [IDX_W-1:0]        w_idx;
    logic signed [MEM_W-1:0] w_mem_rd;
    logic                    w_fired;
    logic signed [MEM_W-1:0] w_new_mem;

    lifnu_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_valid  = (32'(r_in.neuron) < NEURONS);
    assign w_idx    = IDX_W'(r_in.neuron);
    assign w_mem_rd = w_valid ? r_mem[w_idx] : '0;

    lifnu_update u_update (
        .i_item     (r_in),
        .i_membrane (w_mem_rd),
        .i_cfg      (w_cfg),
        .o_fired    (w_fired),
        .o_membrane (w_new_mem)
    );

    assign w_adv      = r_in_v && (!r_out_v || !i_out_stall);
    assign o_in_stall = r_in_v && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_v = r_in_v;
        if (w_accept) begin
            n_in_v = 1'b1;
        end else if (w_adv) begin
            n_in_v = 1'b0;
        end

        n_out_v = r_out_v;
        if (w_adv) begin
            n_out_v = 1'b1;
        end else if (r_out_v && !i_out_stall) begin
            n_out_v = 1'b0;
        end

        n_out.result_neuron  = r_in.neuron;
        n_out.spike_out      = w_fired;
        n_out.membrane_out   = w_new_mem;
        n_out.final_membrane = r_in.last_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEURONS; i++) begin
                r_mem[i] <= '0;
            end
        end else if (w_adv && w_valid) begin
            r_mem[w_idx] <= w_new_mem;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

    `LIFNU_ASSERT_SAME(a_stall_needs_item, o_in_stall, r_in_v, "Input stalled with no held item.")
    `LIFNU_ASSERT_NEXT(a_load_no_spike, w_adv && (r_in.action == ACT_LOAD),
        !o_out_item.spike_out, "Load item produced a spike.")
    `LIFNU_ASSERT_NEXT(a_mem_written, w_adv && w_valid,
        r_mem[$past(w_idx)] == o_out_item.membrane_out, "Stored membrane differs from result.")

endmodule

/* tb/tb_lif_neuron_update_core.sv */
// Self-checking testbench for lif_neuron_update_core: random and directed items,
// per-item prediction of spike and membrane, and reconfiguration between phases.
// Depends on lifnu_pkg and the lif_neuron_update_core RTL.
`timescale 1ns / 1ps

module tb_lif_neuron_update_core;
    import lifnu_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 6;
    localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    lif_neuron_update_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    t_in_item  pending_items[$];
    t_out_item expected_spikes[$];

    logic signed [31:0] cfg_threshold = THRESHOLD_RST;
    logic [15:0]        cfg_gain      = GAIN_RST;
    logic signed [31:0] cfg_reset_lvl = RESET_VALUE_RST;
    logic               cfg_hard      = HARD_MODE_RST;
    logic signed [31:0] membrane_model [16];

    int  n_errors = 0;
    int  n_accepted = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    int  next_hold_at = 300;
    bit  send_quiet = 1'b0;
    bit  recv_quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < 16; i++) membrane_model[i] = '0;
    end

    function automatic longint clamp_q16(input longint v);
        if (v > longint'(Q16_MAX)) return longint'(Q16_MAX);
        if (v < longint'(Q16_MIN)) return longint'(Q16_MIN);
        return v;
    endfunction

    function automatic t_out_item lif_predict(input t_in_item it);
        t_out_item r;
        longint    m;
        longint    dec;
        longint    sum;
        longint    rst;
        r.result_neuron  = it.neuron;
        r.spike_out      = 1'b0;
        r.final_membrane = it.last_step;
        if (it.action == ACT_LOAD) begin
            membrane_model[it.neuron] = it.membrane_load;
            r.membrane_out = it.membrane_load;
        end else begin
            m   = longint'($signed(membrane_model[it.neuron]));
            rst = (cfg_reset_lvl == RESET_MINUS_ONE) ? 64'sd0 : longint'($signed(cfg_reset_lvl));
            dec = (m * longint'({48'd0, cfg_gain}) + 64'sd16384) >>> 15;
            sum = clamp_q16(dec + longint'($signed(it.spike_value)) * 64'sd65536);
            if (sum >= longint'($signed(cfg_threshold))) begin
                r.spike_out = 1'b1;
                sum = cfg_hard ? rst : clamp_q16(sum - rst);
            end
            r.membrane_out = sum[31:0];
            membrane_model[it.neuron] = sum[31:0];
        end
        return r;
    endfunction

    function automatic t_in_item make_item(input t_action act, input logic [3:0] n,
                                           input logic signed [15:0] spk,
                                           input logic signed [31:0] ld, input logic last);
        t_in_item it;
        it.action        = act;
        it.neuron        = n;
        it.spike_value   = spk;
        it.membrane_load = ld;
        it.last_step     = last;
        return it;
    endfunction

    function automatic logic signed [15:0] draw_spike();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return 16'sh7FFF;
        if (sel == 1) return 16'sh8000;
        if (sel < 5) return 16'($urandom);
        return 16'($signed($urandom_range(0, 127)) - 64);
    endfunction

    function automatic logic signed [31:0] draw_membrane();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return Q16_MAX;
        if (sel == 1) return Q16_MIN;
        if (sel < 6) return 32'($urandom);
        return 32'($signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000);
    endfunction

    // Writes one register with a setup and an access phase and updates the local copy.
    task automatic apb_write(input t_reg_idx r, input logic [31:0] d);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_FIRE_THRESHOLD: cfg_threshold = d;
            REG_DECAY_GAIN:     cfg_gain      = d[15:0];
            REG_RESET_VALUE:    cfg_reset_lvl = d;
            REG_HARD_MODE:      cfg_hard      = d[0];
            default: ;
        endcase
    endtask

    task automatic program_cfg(input logic signed [31:0] thr, input logic [15:0] gain,
                               input logic signed [31:0] rst, input logic hard);
        apb_write(REG_FIRE_THRESHOLD, thr);
        apb_write(REG_DECAY_GAIN, {16'd0, gain});
        apb_write(REG_RESET_VALUE, rst);
        apb_write(REG_HARD_MODE, {31'd0, hard});
    endtask

    task automatic program_random_cfg();
        logic signed [31:0] thr;
        logic [15:0]        gain;
        logic signed [31:0] rst;
        case ($urandom_range(0, 5))
            0: thr = Q16_MAX;
            1: thr = Q16_MIN;
            2: thr = 32'($urandom);
            default: thr = 32'($signed($urandom_range(0, 32'h007F_FFFF)) - 32'sh0020_0000);
        endcase
        case ($urandom_range(0, 4))
            0: gain = 16'd0;
            1: gain = 16'hFFFF;
            default: gain = 16'($urandom);
        endcase
        case ($urandom_range(0, 6))
            0: rst = RESET_MINUS_ONE;
            1: rst = '0;
            2: rst = Q16_MAX;
            3: rst = Q16_MIN;
            4: rst = 32'($urandom);
            default: rst = 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
        endcase
        program_cfg(thr, gain, rst, 1'($urandom));
    endtask

    // Mostly step runs on one neuron, usually after a load, with the final step flagged,
    // mixed with unrelated noise items.
    task automatic queue_random_items(input int count);
        int         queued;
        int         steps;
        logic [3:0] n;
        queued = 0;
        while (queued < count) begin
            if ($urandom_range(0, 9) < 8) begin
                n = 4'($urandom);
                if ($urandom_range(0, 4) != 0) begin
                    pending_items.push_back(make_item(ACT_LOAD, n, 16'($urandom),
                                                      draw_membrane(), 1'b0));
                    queued++;
                end
                steps = $urandom_range(1, 12);
                for (int s = 0; s < steps; s++) begin
                    pending_items.push_back(make_item(ACT_STEP, n, draw_spike(),
                                                      32'($urandom), 1'(s == steps - 1)));
                    queued++;
                end
            end else begin
                pending_items.push_back(make_item($urandom_range(0, 1) ? ACT_STEP : ACT_LOAD,
                                                  4'($urandom), draw_spike(),
                                                  draw_membrane(), 1'($urandom)));
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || expected_spikes.size() != 0
               || o_out_valid);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_proc
        int gap;
        bit holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap = 0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_spikes.push_back(lif_predict(i_in_item));
                n_accepted <= n_accepted + 1;
                holding = 1'b0;
            end
            if (!holding) begin
                if (gap > 0) begin
                    gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_in_item  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    gap = send_quiet ? 0 : $urandom_range(0, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : hold_proc
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (n_accepted >= next_hold_at) begin
            hold_left    <= LONG_HOLD;
            next_hold_at <= next_hold_at + 700;
        end
    end

    always @(posedge i_clk) begin : monitor_proc
        int        stall_cnt;
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_spikes.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, o_out_item);
                    n_errors++;
                end else begin
                    want = expected_spikes.pop_front();
                    if (o_out_item.result_neuron !== want.result_neuron) begin
                        $display("%0t: result_neuron exp %0d act %0d", $time,
                                 want.result_neuron, o_out_item.result_neuron);
                        n_errors++;
                    end
                    if (o_out_item.spike_out !== want.spike_out) begin
                        $display("%0t: spike_out exp %0b act %0b", $time,
                                 want.spike_out, o_out_item.spike_out);
                        n_errors++;
                    end
                    if (o_out_item.membrane_out !== want.membrane_out) begin
                        $display("%0t: membrane_out exp %h act %h", $time,
                                 want.membrane_out, o_out_item.membrane_out);
                        n_errors++;
                    end
                    if (o_out_item.final_membrane !== want.final_membrane) begin
                        $display("%0t: final_membrane exp %0b act %0b", $time,
                                 want.final_membrane, o_out_item.final_membrane);
                        n_errors++;
                    end
                end
                stall_cnt = recv_quiet ? 0 : $urandom_range(0, 7);
            end else if (stall_cnt > 0) begin
                stall_cnt--;
            end
            i_out_stall <= (stall_cnt > 0) || (hold_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_lif_neuron_update_core: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default registers: untouched state, firing with hard reset, saturation.
        pending_items.push_back(make_item(ACT_STEP, 4'd0, 16'sd0, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd0, 16'sd1, 32'sd0, 1'b1));
        pending_items.push_back(make_item(ACT_LOAD, 4'd15, 16'sd0, Q16_MAX, 1'b1));
        pending_items.push_back(make_item(ACT_STEP, 4'd15, 16'sh7FFF, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 4'd3, 16'sh7FFF, Q16_MIN, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd3, 16'sh8000, Q16_MAX, 1'b1));
        pending_items.push_back(make_item(ACT_LOAD, 4'd5, 16'sd0, -32'sd3, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd5, 16'sd0, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 4'd7, 16'sd0, 32'sd1, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd7, 16'sd0, 32'sd0, 1'b0));
        wait_drained();

        // Soft subtract of the most negative level saturates high.
        program_cfg(Q16_MAX, 16'hFFFF, Q16_MIN, 1'b0);
        pending_items.push_back(make_item(ACT_LOAD, 4'd1, 16'sd0, Q16_MAX, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd1, 16'sh7FFF, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_LOAD, 4'd2, 16'sd0, Q16_MIN, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd2, 16'sh8000, 32'sd0, 1'b1));
        wait_drained();

        // A reset level of minus one acts as zero in soft and in hard mode.
        program_cfg(Q16_MIN, 16'd0, RESET_MINUS_ONE, 1'b0);
        pending_items.push_back(make_item(ACT_STEP, 4'd4, 16'sh8000, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd4, 16'sh7FFF, 32'sd0, 1'b1));
        wait_drained();
        apb_write(REG_HARD_MODE, 32'd1);
        pending_items.push_back(make_item(ACT_STEP, 4'd6, 16'sd5, 32'sd0, 1'b0));
        wait_drained();

        // Soft subtract of the largest level saturates low.
        program_cfg(Q16_MIN, 16'h8000, Q16_MAX, 1'b0);
        pending_items.push_back(make_item(ACT_STEP, 4'd8, 16'sh8000, 32'sd0, 1'b0));
        pending_items.push_back(make_item(ACT_STEP, 4'd8, 16'sd3, 32'sd0, 1'b1));
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            send_quiet = (p == 1) || (p == 4);
            recv_quiet = (p == 2) || (p == 4);
            program_random_cfg();
            queue_random_items(240);
            wait_drained();
        end

        if (n_errors == 0) begin
            $display("tb_lif_neuron_update_core: PASS");
        end else begin
            $display("tb_lif_neuron_update_core: FAIL");
        end
        $finish;
    end

endmodule
